@@ rtl/core/tama_pkg.sv @@
// shared types and constants for the three-axis moving average angle filter
package tama_pkg;

    localparam int AXES     = 3;
    localparam int AXIS_W   = 2;
    localparam int SAMPLE_W = 16;
    localparam int ANGLE_W  = 23;
    localparam int RECIP_W  = 17;

    typedef enum logic [AXIS_W-1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    // control that travels with each request down the pipeline
    typedef struct packed {
        logic  valid;
        logic  bad;
        t_axis axis;
    } t_ctl;

    // filtered * 90 as a sum of shifts
    function automatic logic signed [ANGLE_W-1:0] times_ninety(
        input logic signed [SAMPLE_W-1:0] f
    );
        logic signed [ANGLE_W-1:0] a;
        a = ANGLE_W'(f);
        return (a <<< 6) + (a <<< 4) + (a <<< 3) + (a <<< 1);
    endfunction

endpackage

@@ rtl/core/tama_ram.sv @@
// generic single write port ram with registered read, read-first
module tama_ram #(
    parameter  int WIDTH  = 16,
    parameter  int DEPTH  = 48,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/three_axis_moving_average_angle.sv @@
// top level: per-axis boxcar moving average of angle samples with fixed-point angle
//
// input channel: i_valid / o_ready carry one request with an axis tag (0 = x, 1 = y,
// 2 = z) and a signed 16-bit sample. output channel: o_valid / i_ready carry one
// result per request: the axis, the moving average of the last DEPTH samples of that
// axis, and that average times 90 in units of 1/16384 degree. axis code 3 touches no
// state and gives a zero result.
// the ram read happens at the accepting edge, then running sum update, reciprocal
// multiply and angle scaling take one register each, the last one driving o_valid.
// throughput is one request per cycle while the receiver does not stall; the
// running sum and the window ram read/write each take one pass per request.
// the window ram holds 3 x DEPTH samples; a per-axis wrap flag marks whether the
// slot about to be replaced was ever written, so slots read as zero until the ring
// first wraps. reset clears positions, sums, wrap flags and all valid flags at once;
// a request can be accepted as soon as reset is released.
// when the receiver stalls with a result held in the output register, the whole
// pipeline freezes and o_ready drops until the result is taken.
module three_axis_moving_average_angle
    import tama_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [AXIS_W-1:0]          i_axis,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [AXIS_W-1:0]          o_axis_out,
    output logic signed [SAMPLE_W-1:0] o_filtered,
    output logic signed [ANGLE_W-1:0]  o_angle_fixed
);

    localparam int POS_W   = $clog2(DEPTH);
    localparam int SUM_W   = SAMPLE_W + POS_W;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int RAM_D   = AXES * DEPTH;
    localparam int ADDR_W  = $clog2(RAM_D);
    localparam int RECIP   = 65536 / DEPTH;
    localparam logic signed [RECIP_W-1:0] RECIP_S = RECIP_W'(RECIP);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(DEPTH - 1);

    // ring state per axis
    logic [POS_W-1:0]        r_pos  [AXES];
    logic [AXES-1:0]         r_wrap;
    logic signed [SUM_W-1:0] r_sum  [AXES];

    // pipeline registers
    t_ctl                          r1_ctl, r2_ctl, r3_ctl;
    logic                          r1_old_ok;
    logic signed [SAMPLE_W-1:0]    r1_sample;
    logic signed [SUM_W-1:0]       r2_sum;
    logic signed [SAMPLE_W-1:0]    r3_filt;
    logic                          r_o_valid;
    t_axis                         r_o_axis;
    logic signed [SAMPLE_W-1:0]    r_o_filt;
    logic signed [ANGLE_W-1:0]     r_o_angle;

    logic                    w_adv;
    logic                    w_acc;
    logic                    w_in_bad;
    logic [1:0]              w_in_sel;
    logic [POS_W-1:0]        w_cur_pos;
    logic [ADDR_W-1:0]       w_addr;
    logic [SAMPLE_W-1:0]     w_rdata;
    logic signed [SAMPLE_W-1:0] w_old;
    logic [1:0]              w_s1_sel;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [PROD_W-1:0] w_prod;

    // pipeline moves unless a result waits on a stalled receiver
    assign w_adv    = !(r_o_valid && !i_ready);
    assign o_ready  = w_adv;
    assign w_acc    = i_valid && w_adv;
    assign w_in_bad = (i_axis == AXIS_NONE);
    assign w_in_sel = w_in_bad ? AXIS_X : i_axis;
    assign w_cur_pos = r_pos[w_in_sel];
    assign w_addr   = ADDR_W'(w_in_sel) * ADDR_W'(DEPTH) + ADDR_W'(w_cur_pos);

    tama_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RAM_D)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_acc && !w_in_bad),
        .i_waddr (w_addr),
        .i_wdata (i_sample),
        .i_re    (w_adv),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // stage 0: ring position, wrap flag, ram access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AXES; k++) begin
                r_pos[k] <= '0;
            end
            r_wrap <= '0;
            r1_ctl <= '{valid: 1'b0, bad: 1'b0, axis: AXIS_X};
        end else if (w_adv) begin
            r1_ctl <= '{valid: i_valid, bad: w_in_bad, axis: t_axis'(i_axis)};
            if (w_acc && !w_in_bad) begin
                if (w_cur_pos == POS_LAST) begin
                    r_pos[w_in_sel]  <= '0;
                    r_wrap[w_in_sel] <= 1'b1;
                end else begin
                    r_pos[w_in_sel] <= w_cur_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_sample <= i_sample;
            r1_old_ok <= r_wrap[w_in_sel];
        end
    end

    // stage 1: running sum update
    assign w_old    = r1_old_ok ? $signed(w_rdata) : '0;
    assign w_s1_sel = r1_ctl.bad ? AXIS_X : r1_ctl.axis;
    assign n_sum    = r_sum[w_s1_sel] + SUM_W'(r1_sample) - SUM_W'(w_old);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AXES; k++) begin
                r_sum[k] <= '0;
            end
            r2_ctl <= '{valid: 1'b0, bad: 1'b0, axis: AXIS_X};
        end else if (w_adv) begin
            r2_ctl <= r1_ctl;
            if (r1_ctl.valid && !r1_ctl.bad) begin
                r_sum[w_s1_sel] <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_sum <= r1_ctl.bad ? '0 : n_sum;
        end
    end

    // stage 2: multiply by truncated reciprocal, floor shift by 16
    assign w_prod = PROD_W'(r2_sum) * PROD_W'(RECIP_S);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '{valid: 1'b0, bad: 1'b0, axis: AXIS_X};
        end else if (w_adv) begin
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_filt <= w_prod[16 +: SAMPLE_W];
        end
    end

    // stage 3: angle scaling into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= r3_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_axis  <= r3_ctl.axis;
            r_o_filt  <= r3_filt;
            r_o_angle <= times_ninety(r3_filt);
        end
    end

    assign o_valid       = r_o_valid;
    assign o_axis_out    = r_o_axis;
    assign o_filtered    = r_o_filt;
    assign o_angle_fixed = r_o_angle;

    // ring positions stay inside the window
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos[0] <= POS_LAST) && (r_pos[1] <= POS_LAST) && (r_pos[2] <= POS_LAST))
        else $error("ring position out of range");

    // unused axis code gives a zero result
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_axis_out == AXIS_NONE)) |-> ((o_filtered == '0) && (o_angle_fixed == '0)))
        else $error("unused axis produced nonzero result");

    // angle is filtered times 90
    a_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle_fixed == ANGLE_W'(o_filtered) * ANGLE_W'(90)))
        else $error("angle does not match filtered value");

    // an accepted request enters the pipeline on the next edge
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r1_ctl.valid)
        else $error("accepted request lost at pipeline entry");

endmodule
